[hdl/pps_pkg.sv]
// pps_pkg: shared types, codes and constants of the panel power sequencer
// and pixel framer; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

   // pixel store size
   localparam int NUM_PIXELS = 4;
   localparam int PIX_W      = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

   // field widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   // frame header byte
   localparam logic [7:0] FRAME_HEADER = 8'hF0;

   // register reset values
   localparam logic [7:0] DISCHARGE_WAIT_RST = 8'd10;
   localparam logic [7:0] OFF_WAIT_RST       = 8'd5;
   localparam logic [7:0] ON_WAIT_RST        = 8'd1;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DISCHARGE_WAIT = 2'd0,
      CSR_OFF_WAIT       = 2'd1,
      CSR_ON_WAIT        = 2'd2
   } csr_index_type;

   // request kinds
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_PIXEL = 2'd1,
      REQ_STEP  = 2'd2
   } req_kind_type;

   // power states
   typedef enum logic [2:0] {
      PWR_DISCHARGE = 3'd0,
      PWR_3V3_OFF   = 3'd1,
      PWR_3V3_ON    = 3'd2,
      PWR_12V_OFF   = 3'd3,
      PWR_12V_ON    = 3'd4
   } power_state_type;

   // colour channel sent next
   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } chan_type;

   // controller states
   typedef enum logic {
      CTRL_IDLE  = 1'b0,
      CTRL_FRAME = 1'b1
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_single;
      logic load_header;
      logic load_byte;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic frame_go;
      logic last_byte;
      logic out_free;
   } dp_status_type;

endpackage : pps_pkg

`default_nettype wire

[hdl/pps_ctrl.sv]
// pps_ctrl: controller state machine; decides when a transaction is taken
// and which result the datapath loads. Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  pps_pkg::dp_status_type status,
   output pps_pkg::ctrl_cmd_type  cmd
);
   import pps_pkg::*;

   ctrl_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (req_tvalid && status.out_free && status.frame_go) state_in = CTRL_FRAME;
         end
         CTRL_FRAME: begin
            if (status.out_free && status.last_byte) state_in = CTRL_IDLE;
         end
         default: state_in = CTRL_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready      = 1'b0;
      cmd             = '0;
      case (state_ff)
         CTRL_IDLE: begin
            req_tready      = status.out_free;
            cmd.accept      = req_tvalid && status.out_free;
            cmd.load_header = cmd.accept && status.frame_go;
            cmd.load_single = cmd.accept && !status.frame_go;
         end
         CTRL_FRAME: begin
            cmd.load_byte = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : pps_ctrl

`default_nettype wire

[hdl/pps_dp.sv]
// pps_dp: datapath; wait registers, power state, tick counter, pixel store,
// frame byte builder and result register. Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_dp (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [1:0]                          req_tuser,  // req_type
   // pixel_index[1:0], red_value[9:2], green_value[17:10], blue_value[25:18],
   // link_active[26], tx_idle[27], zero fill[31:28]
   input  wire  [pps_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // power_state[2:0], rail_3v3_pin[3], rail_12v_pin[4], tx_byte[12:5], zero fill[15:13]
   output logic [pps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser,  // byte_valid
   output logic                                rsp_tlast,  // last_of_run
   input  wire                                 csr_valid,
   input  wire  [pps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [7:0]                          csr_data,
   input  pps_pkg::ctrl_cmd_type               cmd,
   output pps_pkg::dp_status_type              status
);
   import pps_pkg::*;

   // request fields
   logic [1:0] pixel_index;
   logic [7:0] red_value, green_value, blue_value;
   logic       link_active, tx_idle;

   assign pixel_index = req_tdata[1:0];
   assign red_value   = req_tdata[9:2];
   assign green_value = req_tdata[17:10];
   assign blue_value  = req_tdata[25:18];
   assign link_active = req_tdata[26];
   assign tx_idle     = req_tdata[27];

   // registers
   logic [7:0]      discharge_wait_ff, off_wait_ff, on_wait_ff;
   power_state_type seq_state_ff, seq_state_in;
   logic [7:0]      tick_count_ff, tick_count_in;
   logic [23:0]     colour_ff [NUM_PIXELS];
   logic [23:0]     colour_in [NUM_PIXELS];
   logic [NUM_PIXELS-1:0] pending_ff, pending_in;
   chan_type        chan_ff, chan_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      power_state_ff, power_state_in;
   logic            rail_3v3_ff, rail_3v3_in;
   logic            rail_12v_ff, rail_12v_in;
   logic [7:0]      tx_byte_ff, tx_byte_in;
   logic            byte_valid_ff, byte_valid_in;
   logic            last_ff, last_in;

   // lowest pending pixel and its colour
   logic [PIX_W-1:0]      low_idx;
   logic [NUM_PIXELS-1:0] low_onehot;
   logic [23:0]           low_colour;
   logic [7:0]            chan_level;
   logic [7:0]            frame_idx;
   logic [7:0]            frame_byte;

   always_comb begin
      low_idx    = '0;
      low_onehot = '0;
      low_colour = colour_ff[0];
      for (int p = NUM_PIXELS - 1; p >= 0; p--) begin
         if (pending_ff[p]) begin
            low_idx    = PIX_W'(p);
            low_onehot = NUM_PIXELS'(1) << p;
            low_colour = colour_ff[p];
         end
      end
   end

   // channel byte: index nibble over the top three colour bits
   always_comb begin
      case (chan_ff)
         CH_RED:   chan_level = low_colour[23:16];
         CH_GREEN: chan_level = low_colour[15:8];
         CH_BLUE:  chan_level = low_colour[7:0];
         default:  chan_level = 8'd0;
      endcase
      frame_idx  = 8'(low_idx) * 8'd3 + 8'(chan_ff);
      frame_byte = {frame_idx[3:0], 1'b0, chan_level[7:5]};
   end

   // status
   assign status.out_free  = !rsp_valid_ff || rsp_tready;
   assign status.frame_go  = (req_tuser == REQ_STEP) && (seq_state_ff == PWR_12V_ON)
                             && tx_idle && (|pending_ff);
   assign status.last_byte = (chan_ff == CH_BLUE) && ((pending_ff & ~low_onehot) == '0);

   // sequencer, tick counter and pixel store
   always_comb begin
      seq_state_in  = seq_state_ff;
      tick_count_in = tick_count_ff;
      pending_in    = pending_ff;
      chan_in       = chan_ff;
      for (int p = 0; p < NUM_PIXELS; p++) colour_in[p] = colour_ff[p];

      if (cmd.accept) begin
         case (req_tuser)
            REQ_TICK: begin
               if (tick_count_ff != 8'hFF) tick_count_in = tick_count_ff + 8'd1;
            end
            REQ_PIXEL: begin
               for (int p = 0; p < NUM_PIXELS; p++) begin
                  if (pixel_index == 2'(p)) begin
                     colour_in[p]  = {red_value, green_value, blue_value};
                     pending_in[p] = 1'b1;
                  end
               end
            end
            REQ_STEP: begin
               case (seq_state_ff)
                  PWR_DISCHARGE: begin
                     if (tick_count_ff > discharge_wait_ff) begin
                        seq_state_in  = PWR_3V3_ON;
                        tick_count_in = '0;
                     end
                  end
                  PWR_3V3_OFF: begin
                     if (tick_count_ff > off_wait_ff) begin
                        seq_state_in  = PWR_3V3_ON;
                        tick_count_in = '0;
                     end
                  end
                  PWR_3V3_ON: begin
                     if (tick_count_ff > on_wait_ff) begin
                        if (link_active) begin
                           seq_state_in = PWR_12V_ON;
                        end else begin
                           seq_state_in  = PWR_3V3_OFF;
                           tick_count_in = '0;
                        end
                     end
                  end
                  PWR_12V_OFF: begin
                     seq_state_in = PWR_12V_OFF;
                  end
                  PWR_12V_ON: begin
                     seq_state_in = PWR_12V_ON;
                  end
                  default: begin
                     seq_state_in  = PWR_DISCHARGE;
                     tick_count_in = '0;
                  end
               endcase
            end
            default: begin
               seq_state_in = seq_state_ff;
            end
         endcase
      end

      // frame walk over pending pixels, three channels each
      if (cmd.load_header) chan_in = CH_RED;
      if (cmd.load_byte) begin
         if (chan_ff == CH_BLUE) begin
            chan_in    = CH_RED;
            pending_in = pending_ff & ~low_onehot;
         end else if (chan_ff == CH_RED) begin
            chan_in = CH_GREEN;
         end else begin
            chan_in = CH_BLUE;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      power_state_in = power_state_ff;
      rail_3v3_in    = rail_3v3_ff;
      rail_12v_in    = rail_12v_ff;
      tx_byte_in     = tx_byte_ff;
      byte_valid_in  = byte_valid_ff;
      last_in        = last_ff;
      if (cmd.load_single || cmd.load_header || cmd.load_byte) begin
         rsp_valid_in   = 1'b1;
         power_state_in = seq_state_in;
         rail_3v3_in    = seq_state_in inside {PWR_DISCHARGE, PWR_3V3_OFF};
         rail_12v_in    = (seq_state_in == PWR_12V_ON);
         if (cmd.load_header) begin
            tx_byte_in    = FRAME_HEADER;
            byte_valid_in = 1'b1;
            last_in       = 1'b0;
         end else if (cmd.load_byte) begin
            tx_byte_in    = frame_byte;
            byte_valid_in = 1'b1;
            last_in       = status.last_byte;
         end else begin
            tx_byte_in    = 8'd0;
            byte_valid_in = 1'b0;
            last_in       = 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         discharge_wait_ff <= DISCHARGE_WAIT_RST;
         off_wait_ff       <= OFF_WAIT_RST;
         on_wait_ff        <= ON_WAIT_RST;
         seq_state_ff      <= PWR_DISCHARGE;
         tick_count_ff     <= '0;
         pending_ff        <= '0;
         chan_ff           <= CH_RED;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_DISCHARGE_WAIT: discharge_wait_ff <= csr_data;
               CSR_OFF_WAIT:       off_wait_ff       <= csr_data;
               CSR_ON_WAIT:        on_wait_ff        <= csr_data;
               default:            on_wait_ff        <= on_wait_ff;
            endcase
         end
         seq_state_ff  <= seq_state_in;
         tick_count_ff <= tick_count_in;
         pending_ff    <= pending_in;
         chan_ff       <= chan_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int p = 0; p < NUM_PIXELS; p++) colour_ff[p] <= colour_in[p];
      power_state_ff <= power_state_in;
      rail_3v3_ff    <= rail_3v3_in;
      rail_12v_ff    <= rail_12v_in;
      tx_byte_ff     <= tx_byte_in;
      byte_valid_ff  <= byte_valid_in;
      last_ff        <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, tx_byte_ff, rail_12v_ff, rail_3v3_ff, power_state_ff};
   assign rsp_tuser  = byte_valid_ff;
   assign rsp_tlast  = last_ff;

endmodule : pps_dp

`default_nettype wire

[hdl/panel_power_sequencer_pixel_framer_unit.sv]
// panel_power_sequencer_pixel_framer_unit: top level; joins the controller
// (pps_ctrl) and the datapath (pps_dp). Depends on pps_pkg.
//
//   channel  direction  handshake              payload
//   req_     in         req_tvalid/req_tready  tuser req_type, tdata pixel and link fields
//   rsp_     out        rsp_tvalid/rsp_tready  tdata state, pins, byte; tuser byte_valid; tlast
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// ticks, pixel writes and steps that send no frame give one result each; a frame
// step gives a header byte and then three bytes for each pending pixel, one byte
// per cycle while the result register is not stalled, through the single result
// register, and the input is held off until its last byte is loaded. a stalled
// result register stalls the input. reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module panel_power_sequencer_pixel_framer_unit (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [1:0]                      req_tuser,  // req_type
   // pixel_index[1:0], red_value[9:2], green_value[17:10], blue_value[25:18],
   // link_active[26], tx_idle[27], zero fill[31:28]
   input  wire  [pps_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // power_state[2:0], rail_3v3_pin[3], rail_12v_pin[4], tx_byte[12:5], zero fill[15:13]
   output logic [pps_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,  // byte_valid
   output logic                            rsp_tlast,  // last_of_run
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [pps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [7:0]                      csr_data
);
   import pps_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pps_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule : panel_power_sequencer_pixel_framer_unit

`default_nettype wire

[hdl/pps_checker.sv]
// pps_checker: port-level checks of the top level, bound to it below.
// Depends on pps_pkg for widths only.
`timescale 1ns / 1ps
`default_nettype none

module pps_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire [1:0]                       req_tuser,
   input wire [pps_pkg::REQ_DATA_W-1:0]   req_tdata,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [pps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire                             rsp_tuser,
   input wire                             rsp_tlast,
   input wire                             csr_valid,
   input wire                             csr_ready,
   input wire [pps_pkg::CSR_IDX_W-1:0]    csr_index,
   input wire [7:0]                       csr_data
);
   import pps_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a result without a frame byte is a single closing result with zero byte
   a_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[12:5] == 8'd0))
      else $error("non-frame result malformed");

   // rail pins follow the power state
   a_rails: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4] == (rsp_tdata[2:0] == 3'd4))
         && (rsp_tdata[3] == ((rsp_tdata[2:0] == 3'd0) || (rsp_tdata[2:0] == 3'd1))))
      else $error("rail pins disagree with power state");

   // input held off while a frame is still going out
   a_frame_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && !rsp_tlast |-> !req_tready)
      else $error("input taken during a frame");

   // frame bytes only in 12 v on
   a_frame_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[2:0] == 3'd4)
      else $error("frame byte outside 12 v on");

endmodule : pps_checker

bind panel_power_sequencer_pixel_framer_unit pps_checker u_pps_checker (.*);

`default_nettype wire
